// ===== design/rlp_hdr_pkg.sv =====
// Shared types, codes and a helper function for the RLP list header rewriter.
// Used by every module of the block except rlp_hdr_fifo; depends on nothing else.
package rlp_hdr_pkg;

  // Long-list prefix base: a long list header is HDR_BASE plus its length byte count.
  localparam logic [7:0] HDR_BASE = 8'hf7;
  // New lengths must fit in this many bits.
  localparam int LEN_LIMIT_BITS = 56;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam int SKIP_W = 3;
  localparam logic [3:0] TAIL_TRIM_RST = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM_MODE = 1'b0,
    REG_TAIL_TRIM = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       trim_mode;
    logic [3:0] tail_trim;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } out_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LEN  = 3'b010,
    F_PAY  = 3'b100
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_HDR  = 2'b10
  } back_state_t;

  // Size in bytes of the RLP item that encodes a 32-bit nonce.
  function automatic logic [SKIP_W-1:0] nonce_skip(input logic [31:0] nonce);
    logic [SKIP_W-1:0] n;
    if (nonce[31:24] != 8'h00) begin
      n = SKIP_W'(5);
    end else if (nonce[23:16] != 8'h00) begin
      n = SKIP_W'(4);
    end else if (nonce[15:8] != 8'h00) begin
      n = SKIP_W'(3);
    end else if (nonce[7] != 1'b0) begin
      n = SKIP_W'(2);
    end else begin
      n = SKIP_W'(1);
    end
    return n;
  endfunction

endpackage

// ===== design/rlp_hdr_fifo.sv =====
// Small first-in first-out queue built from registers.
// Generic; uses no package. Instantiated by rlp_list_header_rewriter.
module rlp_hdr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo occupancy exceeds its depth");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("fifo occupancy did not grow on a lone push");
`endif

endmodule

// ===== design/rlp_hdr_front.sv =====
// Front end: parses the source message byte by byte and issues commands.
// Depends on rlp_hdr_pkg for the command, configuration and state types.
module rlp_hdr_front #(
  parameter int MAX_LEN_BYTES = 4,
  localparam int LW = 8 * MAX_LEN_BYTES,
  localparam int LBL_W = $clog2(MAX_LEN_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_start_req,
  input  logic [31:0]         in_nonce_value,
  input  rlp_hdr_pkg::cfg_t   cfg,
  output logic                cmd_push,
  output rlp_hdr_pkg::cmd_t   cmd,
  output logic [LW-1:0]       cmd_len
);

  rlp_hdr_pkg::front_state_t         phase_r, phase_nxt;
  logic [LBL_W-1:0]                  lbl_r, lbl_nxt;
  logic [LW-1:0]                     len_r, len_nxt;
  logic [rlp_hdr_pkg::SKIP_W-1:0]    skip_r, skip_nxt;

  logic [LW-1:0]    len_acc;
  logic [LW-1:0]    len_sub;
  logic [3:0]       drop;
  logic             over;
  logic             prefix_ok;
  logic [LBL_W-1:0] lbl_dec;

  assign len_acc   = (len_r << 8) | LW'(in_byte);
  assign drop      = cfg.trim_mode ? 4'(skip_r) : cfg.tail_trim;
  assign len_sub   = len_acc - LW'(drop);
  assign over      = (LW > rlp_hdr_pkg::LEN_LIMIT_BITS) &&
                     ((len_acc >> rlp_hdr_pkg::LEN_LIMIT_BITS) != '0);
  assign prefix_ok = (in_byte > rlp_hdr_pkg::HDR_BASE) &&
                     ({1'b0, in_byte} <= 9'(int'(rlp_hdr_pkg::HDR_BASE) + MAX_LEN_BYTES));
  assign lbl_dec   = lbl_r - 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    lbl_nxt   = lbl_r;
    len_nxt   = len_r;
    skip_nxt  = skip_r;
    cmd_push  = 1'b0;
    cmd       = '{kind: rlp_hdr_pkg::CMD_DATA, data: in_byte, last: 1'b0};
    cmd_len   = len_sub;
    if (accept) begin
      priority if (in_start_req) begin
        if (prefix_ok) begin
          phase_nxt = rlp_hdr_pkg::F_LEN;
          lbl_nxt   = LBL_W'(in_byte - rlp_hdr_pkg::HDR_BASE);
          len_nxt   = '0;
          skip_nxt  = rlp_hdr_pkg::nonce_skip(in_nonce_value);
        end else begin
          phase_nxt = rlp_hdr_pkg::F_IDLE;
          lbl_nxt   = '0;
          skip_nxt  = '0;
          cmd_push  = 1'b1;
          cmd.kind  = rlp_hdr_pkg::CMD_ERR;
        end
      end else begin
        unique case (phase_r)
          rlp_hdr_pkg::F_IDLE: begin
          end
          rlp_hdr_pkg::F_LEN: begin
            len_nxt = len_acc;
            lbl_nxt = lbl_dec;
            if (lbl_dec == '0) begin
              // Length complete: check and shorten it; hand a header or an error to the back end.
              if (!cfg.trim_mode) begin
                skip_nxt = '0;
              end
              cmd_push = 1'b1;
              if (over || (len_acc < LW'(drop))) begin
                phase_nxt = rlp_hdr_pkg::F_IDLE;
                skip_nxt  = '0;
                cmd.kind  = rlp_hdr_pkg::CMD_ERR;
              end else begin
                cmd.kind = rlp_hdr_pkg::CMD_HDR;
                len_nxt  = len_sub;
                if (len_sub == '0) begin
                  phase_nxt = rlp_hdr_pkg::F_IDLE;
                  skip_nxt  = '0;
                end else begin
                  phase_nxt = rlp_hdr_pkg::F_PAY;
                end
              end
            end
          end
          rlp_hdr_pkg::F_PAY: begin
            if (skip_r != '0) begin
              skip_nxt = skip_r - 1'b1;
            end else begin
              // len_r counts the payload bytes still to be passed through.
              cmd_push = 1'b1;
              len_nxt  = len_r - 1'b1;
              if (len_r == LW'(1)) begin
                cmd.last  = 1'b1;
                phase_nxt = rlp_hdr_pkg::F_IDLE;
              end
            end
          end
          default: begin
            phase_nxt = rlp_hdr_pkg::F_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rlp_hdr_pkg::F_IDLE;
      lbl_r   <= '0;
      len_r   <= '0;
      skip_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
    end
  end

`ifndef SYNTH
  a_len_bytes_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rlp_hdr_pkg::F_LEN) |-> (lbl_r != '0))
    else $error("length phase with no length bytes pending");

  a_payload_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rlp_hdr_pkg::F_PAY) |-> (len_r != '0))
    else $error("payload phase with no payload bytes left");
`endif

endmodule

// ===== design/rlp_hdr_back.sv =====
// Back end: turns commands into output bytes, expanding a header command
// into its prefix and length bytes. Depends on rlp_hdr_pkg.
module rlp_hdr_back #(
  parameter int MAX_LEN_BYTES = 4,
  localparam int LW = 8 * MAX_LEN_BYTES,
  localparam int CNT_W = $clog2(MAX_LEN_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  rlp_hdr_pkg::cmd_t   cmd,
  input  logic [LW-1:0]       cmd_len,
  output logic                cmd_pop,
  input  logic                out_full,
  output logic                out_push,
  output rlp_hdr_pkg::out_t   out_item
);

  rlp_hdr_pkg::back_state_t state_r, state_nxt;
  logic [LW-1:0]    hdr_len_r, hdr_len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             zero_r, zero_nxt;
  logic [CNT_W-1:0] n_bytes;
  logic [7:0]       len_byte;

  function automatic logic [CNT_W-1:0] byte_count(input logic [LW-1:0] v);
    logic [CNT_W-1:0] n;
    n = CNT_W'(1);
    for (int i = 1; i < MAX_LEN_BYTES; i++) begin
      if (v[8*i +: 8] != 8'h00) begin
        n = CNT_W'(i + 1);
      end
    end
    return n;
  endfunction

  assign n_bytes = byte_count(cmd_len);

  // Length bytes go out most significant first; cnt_r selects the next one.
  always_comb begin
    len_byte = 8'h00;
    for (int i = 0; i < MAX_LEN_BYTES; i++) begin
      if (cnt_r == CNT_W'(i + 1)) begin
        len_byte = hdr_len_r[8*i +: 8];
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    hdr_len_nxt = hdr_len_r;
    cnt_nxt     = cnt_r;
    zero_nxt    = zero_r;
    cmd_pop     = 1'b0;
    out_push    = 1'b0;
    out_item    = '{data: cmd.data, last: cmd.last, bad: 1'b0};
    unique case (state_r)
      rlp_hdr_pkg::B_IDLE: begin
        if (!cmd_empty && !out_full) begin
          cmd_pop  = 1'b1;
          out_push = 1'b1;
          unique case (cmd.kind)
            rlp_hdr_pkg::CMD_DATA: begin
            end
            rlp_hdr_pkg::CMD_HDR: begin
              out_item    = '{data: rlp_hdr_pkg::HDR_BASE + 8'(n_bytes),
                              last: 1'b0, bad: 1'b0};
              hdr_len_nxt = cmd_len;
              cnt_nxt     = n_bytes;
              zero_nxt    = (cmd_len == '0);
              state_nxt   = rlp_hdr_pkg::B_HDR;
            end
            rlp_hdr_pkg::CMD_ERR: begin
              out_item = '{data: 8'h00, last: 1'b1, bad: 1'b1};
            end
            default: begin
              out_push = 1'b0;
            end
          endcase
        end
      end
      rlp_hdr_pkg::B_HDR: begin
        if (!out_full) begin
          out_push = 1'b1;
          // A zero new length ends the message on its single length byte.
          out_item = '{data: len_byte, last: zero_r && (cnt_r == CNT_W'(1)), bad: 1'b0};
          cnt_nxt  = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = rlp_hdr_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rlp_hdr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlp_hdr_pkg::B_IDLE;
      cnt_r   <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_len_r <= hdr_len_nxt;
  end

`ifndef SYNTH
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlp_hdr_pkg::B_HDR) |-> ((cnt_r != '0) && (cnt_r <= CNT_W'(MAX_LEN_BYTES))))
    else $error("header expansion with an out-of-range byte count");
`endif

endmodule

// ===== design/rlp_list_header_rewriter.sv =====
// RLP long-list header rewriter, top level: config registers, parser front end,
// command queue, header expanding back end and output queue. Uses rlp_hdr_pkg.
// Throughput: one input byte per cycle unless in_full is high; the back end emits one
// byte per cycle unless the output queue is full, so the extra prefix and length bytes
// of an expanded header are absorbed by the command queue.
// Reset (synchronous, rst_n low) empties both queues and returns parsing to idle.
module rlp_list_header_rewriter #(
  parameter int MAX_LEN_BYTES = 4,
  parameter int CMD_DEPTH = 8,
  parameter int OUT_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [7:0]                          in_byte,
  input  logic                                in_start_req,
  input  logic [31:0]                         in_nonce_value,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [7:0]                          out_byte,
  output logic                                out_last,
  output logic                                out_bad_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlp_hdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlp_hdr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW = 8 * MAX_LEN_BYTES;
  localparam int CMD_W = $bits(rlp_hdr_pkg::cmd_t) + LW;
  localparam int OUT_W = $bits(rlp_hdr_pkg::out_t);

  rlp_hdr_pkg::cfg_t cfg_r, cfg_nxt;

  logic              accept;
  logic              cmd_push;
  rlp_hdr_pkg::cmd_t cmd_in;
  logic [LW-1:0]     cmd_len_in;
  logic [CMD_W-1:0]  cmd_rd;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  rlp_hdr_pkg::cmd_t cmd_q;
  logic [LW-1:0]     cmd_len_q;

  logic              out_push;
  rlp_hdr_pkg::out_t out_item;
  logic [OUT_W-1:0]  out_rd;
  logic              out_full;
  rlp_hdr_pkg::out_t out_q;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (rlp_hdr_pkg::cfg_reg_t'(cfg_index))
        rlp_hdr_pkg::REG_TRIM_MODE: cfg_nxt.trim_mode = cfg_data[0];
        rlp_hdr_pkg::REG_TAIL_TRIM: cfg_nxt.tail_trim = cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{trim_mode: 1'b0, tail_trim: rlp_hdr_pkg::TAIL_TRIM_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  rlp_hdr_front #(
    .MAX_LEN_BYTES(MAX_LEN_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_start_req  (in_start_req),
    .in_nonce_value(in_nonce_value),
    .cfg           (cfg_r),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_len       (cmd_len_in)
  );

  rlp_hdr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_data({cmd_in, cmd_len_in}),
    .pop    (cmd_pop),
    .rd_data(cmd_rd),
    .full   (cmd_full),
    .empty  (cmd_empty)
  );

  assign cmd_q     = cmd_rd[LW +: $bits(rlp_hdr_pkg::cmd_t)];
  assign cmd_len_q = cmd_rd[LW-1:0];

  rlp_hdr_back #(
    .MAX_LEN_BYTES(MAX_LEN_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_q),
    .cmd_len  (cmd_len_q),
    .cmd_pop  (cmd_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_item (out_item)
  );

  rlp_hdr_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (out_push),
    .wr_data(out_item),
    .pop    (out_pop),
    .rd_data(out_rd),
    .full   (out_full),
    .empty  (out_empty)
  );

  assign out_q         = out_rd;
  assign out_byte      = out_q.data;
  assign out_last      = out_q.last;
  assign out_bad_frame = out_q.bad;

endmodule

// ===== tb/sv/rlp_list_header_rewriter_tb.sv =====
// Self-checking testbench for rlp_list_header_rewriter: directed rows, then random RLP
// messages under several register settings, checked against a predictor of the rewrite.
// Depends on rlp_hdr_pkg and the rlp_list_header_rewriter RTL.
module rlp_list_header_rewriter_tb;

  localparam int MAX_LEN_BYTES = 4;
  localparam logic [63:0] NEW_LEN_MAX = 64'h00ff_ffff_ffff_ffff;

  typedef enum logic [1:0] {
    ROW_CHECK,
    ROW_QUIET,
    ROW_BAD
  } row_kind_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  data;
    logic [31:0] nonce;
    row_kind_t   kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [7:0] in_byte = 8'h00;
  logic in_start_req = 1'b0;
  logic [31:0] in_nonce_value = 32'h0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_byte;
  logic out_last;
  logic out_bad_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rlp_hdr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rlp_hdr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rlp_list_header_rewriter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_byte(in_byte),
    .in_start_req(in_start_req),
    .in_nonce_value(in_nonce_value),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_byte(out_byte),
    .out_last(out_last),
    .out_bad_frame(out_bad_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state and its copy of the registers.
  logic                      mode_nonce = 1'b0;
  logic [3:0]                tail_drop = rlp_hdr_pkg::TAIL_TRIM_RST;
  rlp_hdr_pkg::front_state_t parse_state = rlp_hdr_pkg::F_IDLE;
  int                        len_bytes_left = 0;
  logic [63:0]               new_len = '0;
  logic [63:0]               pay_pos = '0;
  int                        nonce_skip_left = 0;

  rlp_hdr_pkg::out_t step_bytes[$];
  rlp_hdr_pkg::out_t pending_bytes[$];
  int   errors = 0;
  int   in_run = 0;
  int   out_run = 0;

  dir_row_t dir_rows[25] = '{
    '{1'b0, 8'h55, 32'h0000_0000, ROW_QUIET},
    '{1'b1, 8'hf7, 32'h0000_0000, ROW_BAD},
    '{1'b1, 8'hfc, 32'h0000_0000, ROW_BAD},
    '{1'b1, 8'h00, 32'h0000_0000, ROW_BAD},
    '{1'b1, 8'hff, 32'hffff_ffff, ROW_BAD},
    '{1'b1, 8'hf8, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'h03, 32'h0000_0000, ROW_CHECK},
    '{1'b0, 8'haa, 32'h0000_0000, ROW_QUIET},
    '{1'b1, 8'hf8, 32'h0000_007f, ROW_QUIET},
    '{1'b0, 8'h02, 32'h0000_0000, ROW_BAD},
    '{1'b1, 8'hfb, 32'h0000_0080, ROW_QUIET},
    '{1'b0, 8'hff, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'hff, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'hff, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'hff, 32'h0000_0000, ROW_CHECK},
    '{1'b0, 8'h00, 32'h0000_0000, ROW_CHECK},
    '{1'b0, 8'hff, 32'hffff_ffff, ROW_CHECK},
    '{1'b1, 8'hf9, 32'h0001_0000, ROW_QUIET},
    '{1'b0, 8'h00, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'h05, 32'h0000_0000, ROW_CHECK},
    '{1'b0, 8'h12, 32'h0000_0000, ROW_CHECK},
    '{1'b0, 8'h34, 32'h0000_0000, ROW_CHECK},
    '{1'b0, 8'h56, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'h78, 32'h0000_0000, ROW_QUIET},
    '{1'b0, 8'h9a, 32'h0000_0000, ROW_QUIET}
  };

  function automatic int byte_len(input logic [63:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (8 * n)) != 0) n++;
    return n;
  endfunction

  // Size of the RLP item that encodes the nonce.
  function automatic int nonce_item_size(input logic [31:0] nonce);
    return (nonce < 32'h80) ? 1 : 1 + byte_len({32'h0, nonce});
  endfunction

  function automatic logic [31:0] rand_nonce();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 127);
      1: return $urandom_range(128, 255);
      2: return $urandom & 32'h0000_ffff;
      3: return $urandom & 32'h00ff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Gap before the next transaction, with occasional runs of back-to-back traffic.
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic void frame_error();
    parse_state = rlp_hdr_pkg::F_IDLE;
    len_bytes_left = 0;
    nonce_skip_left = 0;
    step_bytes.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
  endfunction

  // Computes the rewritten bytes that one source byte releases.
  function automatic void rewrite_byte(input logic st, input logic [7:0] d,
                                       input logic [31:0] nonce);
    logic [63:0] drop;
    int n;
    step_bytes.delete();
    if (st) begin
      if (d <= rlp_hdr_pkg::HDR_BASE || d > rlp_hdr_pkg::HDR_BASE + MAX_LEN_BYTES) begin
        frame_error();
        return;
      end
      len_bytes_left = d - rlp_hdr_pkg::HDR_BASE;
      new_len = '0;
      pay_pos = '0;
      nonce_skip_left = nonce_item_size(nonce);
      parse_state = rlp_hdr_pkg::F_LEN;
      return;
    end
    if (parse_state == rlp_hdr_pkg::F_LEN) begin
      new_len = (new_len << 8) | d;
      if (len_bytes_left > 0) len_bytes_left--;
      if (len_bytes_left != 0) return;
      if (mode_nonce) begin
        drop = nonce_skip_left;
      end else begin
        drop = tail_drop;
        nonce_skip_left = 0;
      end
      if (new_len > NEW_LEN_MAX || new_len < drop) begin
        frame_error();
        return;
      end
      new_len -= drop;
      n = byte_len(new_len);
      step_bytes.push_back('{data: 8'(rlp_hdr_pkg::HDR_BASE + n), last: 1'b0, bad: 1'b0});
      for (int i = n - 1; i >= 0; i--) begin
        step_bytes.push_back('{data: new_len[8*i +: 8], last: 1'b0, bad: 1'b0});
      end
      if (new_len == 0) begin
        step_bytes[n].last = 1'b1;
        parse_state = rlp_hdr_pkg::F_IDLE;
        nonce_skip_left = 0;
      end else begin
        parse_state = rlp_hdr_pkg::F_PAY;
      end
      return;
    end
    if (parse_state == rlp_hdr_pkg::F_PAY) begin
      if (nonce_skip_left > 0) begin
        nonce_skip_left--;
        return;
      end
      pay_pos++;
      if (pay_pos >= new_len) begin
        parse_state = rlp_hdr_pkg::F_IDLE;
        step_bytes.push_back('{data: d, last: 1'b1, bad: 1'b0});
      end else begin
        step_bytes.push_back('{data: d, last: 1'b0, bad: 1'b0});
      end
    end
  endfunction

  task automatic feed_byte(input logic st, input logic [7:0] d, input logic [31:0] nonce,
                           input row_kind_t kind);
    int gap;
    gap = draw_gap(in_run);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= d;
    in_start_req <= st;
    in_nonce_value <= nonce;
    do @(posedge clk); while (in_full);
    rewrite_byte(st, d, nonce);
    case (kind)
      ROW_CHECK: foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      ROW_BAD: pending_bytes.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
      default: ;
    endcase
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input rlp_hdr_pkg::cfg_reg_t idx,
                           input logic [rlp_hdr_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rlp_hdr_pkg::REG_TRIM_MODE) mode_nonce = value[0];
    else tail_drop = value;
  endtask

  // Waits until every expected byte has come out, then lets any work in flight settle.
  task automatic drain();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One random message: mostly well formed, sometimes a bad prefix, an underflowing
  // length, a huge length that is abandoned, a cut-short payload or surplus bytes.
  task automatic send_message(output int sent);
    int roll;
    int k;
    int drop;
    int n_pay;
    logic [31:0] nonce;
    logic [31:0] src_len;
    logic [7:0] pfx;
    roll = $urandom_range(0, 99);
    nonce = rand_nonce();
    drop = mode_nonce ? nonce_item_size(nonce) : int'(tail_drop);
    sent = 0;
    if (roll < 6) begin
      do pfx = $urandom_range(0, 255);
      while (pfx > rlp_hdr_pkg::HDR_BASE && pfx <= rlp_hdr_pkg::HDR_BASE + 4);
      feed_byte(1'b1, pfx, nonce, ROW_CHECK);
      sent = 1;
      return;
    end
    if (roll < 14) begin
      src_len = $urandom;
      n_pay = $urandom_range(0, 6);
    end else if (roll < 22 && drop > 0) begin
      src_len = $urandom_range(0, drop - 1);
      n_pay = 0;
    end else begin
      src_len = drop + ((roll < 30) ? 0 : $urandom_range(1, 14));
      n_pay = src_len;
      if (roll % 7 == 0) n_pay = $urandom_range(0, src_len);
      else if (roll % 5 == 0) n_pay = src_len + $urandom_range(1, 3);
    end
    k = $urandom_range(1, MAX_LEN_BYTES);
    if (k < 4) src_len &= (32'h1 << (8 * k)) - 1;
    if (k < byte_len({32'h0, src_len})) k = byte_len({32'h0, src_len});
    feed_byte(1'b1, 8'(rlp_hdr_pkg::HDR_BASE + k), nonce, ROW_CHECK);
    for (int i = k - 1; i >= 0; i--) feed_byte(1'b0, src_len[8*i +: 8], $urandom, ROW_CHECK);
    for (int i = 0; i < n_pay; i++) feed_byte(1'b0, 8'($urandom), $urandom, ROW_CHECK);
    sent = 1 + k + n_pay;
    // Stray bytes outside a message, usually ignored by an idle parser.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) feed_byte(1'b0, 8'($urandom), $urandom, ROW_CHECK);
    end
  endtask

  // Result side: pops with random stalls and checks each transaction in order.
  initial begin
    int gap;
    rlp_hdr_pkg::out_t got;
    rlp_hdr_pkg::out_t want;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(out_run);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got = '{data: out_byte, last: out_last, bad: out_bad_frame};
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h out_last %b out_bad_frame %b",
               got.data, got.last, got.bad);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.data !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, got.data);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, got.last);
          errors++;
        end
        if (got.bad !== want.bad) begin
          $error("out_bad_frame: expected %b, got %b", want.bad, got.bad);
          errors++;
        end
      end
    end
  end

  initial begin
    logic trim;
    logic [3:0] tail;
    int sent;
    int count;
    logic phase_trim[6];
    logic [3:0] phase_tail[6];
    phase_trim = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_tail = '{4'd3, 4'd15, 4'd0, 4'd0, 4'd7, 4'd15};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run with the register values after reset.
    foreach (dir_rows[i]) begin
      feed_byte(dir_rows[i].start, dir_rows[i].data, dir_rows[i].nonce, dir_rows[i].kind);
    end
    in_push <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      trim = (p < 4) ? phase_trim[p] : 1'($urandom_range(0, 1));
      tail = (p < 4) ? phase_tail[p] : 4'($urandom_range(0, 15));
      // The upper bits of a trim_mode write are don't-care.
      if ($urandom_range(0, 1)) begin
        write_reg(rlp_hdr_pkg::REG_TRIM_MODE, {3'($urandom), trim});
        write_reg(rlp_hdr_pkg::REG_TAIL_TRIM, tail);
      end else begin
        write_reg(rlp_hdr_pkg::REG_TAIL_TRIM, tail);
        write_reg(rlp_hdr_pkg::REG_TRIM_MODE, {3'($urandom), trim});
      end
      cfg_valid <= 1'b0;
      count = 0;
      while (count < 30) begin
        send_message(sent);
        count += sent;
      end
      in_push <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("rlp_list_header_rewriter_tb OK");
    end else begin
      $display("rlp_list_header_rewriter_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("rlp_list_header_rewriter_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rlp_hdr_pkg.sv
design/rlp_hdr_fifo.sv
design/rlp_hdr_front.sv
design/rlp_hdr_back.sv
design/rlp_list_header_rewriter.sv
tb/sv/rlp_list_header_rewriter_tb.sv
